// File: hdl/stt_pkg.sv
// Shared types and constants for the software timer slot table.
package stt_pkg;

  localparam int unsigned IdW    = 31;
  localparam int unsigned TickW  = 64;
  localparam int unsigned DurW   = 32;
  localparam int unsigned MptW   = 10;
  localparam int unsigned KindW  = 3;

  localparam logic [1:0] CMD_TICK   = 2'd0;
  localparam logic [1:0] CMD_ADD    = 2'd1;
  localparam logic [1:0] CMD_CANCEL = 2'd2;
  localparam logic [1:0] CMD_NONE   = 2'd3;

  localparam logic [KindW-1:0] KIND_ADDED  = 3'd0;
  localparam logic [KindW-1:0] KIND_FULL   = 3'd1;
  localparam logic [KindW-1:0] KIND_FIRED  = 3'd2;
  localparam logic [KindW-1:0] KIND_TICK   = 3'd3;
  localparam logic [KindW-1:0] KIND_CANCEL = 3'd4;

  localparam logic [MptW-1:0] MPT_RESET = 10'd10;
  localparam logic [IdW-1:0]  ID_MAX    = 31'h7FFF_FFFF;

  // One timer slot; id zero marks the slot free
  typedef struct packed {
    logic [IdW-1:0]   id;
    logic [TickW-1:0] deadline;
    logic [DurW-1:0]  period;
  } slot_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_SCAN,
    ST_FIN
  } state_t;

endpackage

// File: hdl/stt_cell.sv
// One slot cell of the rotating slot ring.
module stt_cell (
  input  logic          clk,
  input  logic          rst,
  input  logic          shift,
  input  stt_pkg::slot_t d_in,
  output stt_pkg::slot_t q
);
  import stt_pkg::*;

  // Owner id is control state and is cleared on reset; deadline and period
  // are only read for occupied slots
  always_ff @(posedge clk) begin
    if (rst) begin
      q.id <= '0;
    end else if (shift) begin
      q.id <= d_in.id;
    end
    if (shift) begin
      q.deadline <= d_in.deadline;
      q.period   <= d_in.period;
    end
  end

endmodule

// File: hdl/stt_div.sv
// Restoring serial divider, one quotient bit per cycle.
module stt_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [stt_pkg::DurW-1:0]   dividend,
  input  logic [stt_pkg::MptW-1:0]   divisor,
  output logic                       done,
  output logic [stt_pkg::DurW-1:0]   quotient
);
  import stt_pkg::*;

  localparam int unsigned CntW = $clog2(DurW);

  logic                busy;
  logic [CntW-1:0]     cnt;
  logic [MptW-1:0]     rem;
  logic [MptW-1:0]     dvs;
  logic [MptW:0]       sh;
  logic                ge;

  // Trial subtraction for the next quotient bit
  always_comb begin
    sh = {rem, quotient[DurW-1]};
    ge = (sh >= {1'b0, dvs});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CntW'(DurW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dvs      <= divisor;
    end else if (busy) begin
      quotient <= {quotient[DurW-2:0], ge};
      rem      <= ge ? MptW'(sh - {1'b0, dvs}) : sh[MptW-1:0];
    end
  end

endmodule

// File: hdl/software_timer_table_core.sv
// Top level of the software timer slot table.
// The slots sit in a ring of cells that rotates by one slot per cycle while
// an item scans it and the output register is free; a tick, cancel or add
// item walks the ring once, in slot order, and then gives its final result
// from a finish state. An add first converts milliseconds to ticks in a
// serial divider, then walks the ring. Each fired timer and each final
// result waits for the output register to be free, so output stalls
// lengthen an item. Input is taken only between items.
module software_timer_table_core #(
  parameter int SLOTS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [stt_pkg::MptW-1:0]    cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  cmd,
  input  logic [stt_pkg::DurW-1:0]    duration_ms,
  input  logic                        periodic,
  input  logic [stt_pkg::IdW-1:0]     cancel_id,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [stt_pkg::KindW-1:0]   kind,
  output logic [stt_pkg::IdW-1:0]     timer_id,
  output logic [stt_pkg::TickW-1:0]   tick_count,
  output logic                        last
);
  import stt_pkg::*;

  localparam int unsigned CW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  state_t          state, state_next;
  logic [1:0]      op;
  logic            per;
  logic [IdW-1:0]  cid;
  logic [DurW-1:0] tval;
  logic            hit, hit_next;
  logic [CW-1:0]   cnt;
  logic [TickW-1:0] tick;
  logic [IdW-1:0]  next_id;
  logic [MptW-1:0] mpt;

  logic            accept, out_free, step, emit, div_start, div_done;
  logic [DurW-1:0] div_q;
  logic [KindW-1:0] emit_kind;
  logic [IdW-1:0]  emit_id;
  logic            emit_last;

  slot_t           ring [SLOTS];
  slot_t           head, wb;

  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != ST_IDLE);
  assign head     = ring[0];

  // Ring of slot cells; the last cell takes the written-back head
  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    slot_t din;
    if (i == SLOTS - 1) begin : g_tail
      assign din = wb;
    end else begin : g_mid
      assign din = ring[i+1];
    end
    stt_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .shift (step),
      .d_in  (din),
      .q     (ring[i])
    );
  end

  stt_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (duration_ms),
    .divisor  ((mpt == '0) ? MptW'(1) : mpt),
    .done     (div_done),
    .quotient (div_q)
  );

  // Sequencer: next state, head write-back and result selection
  always_comb begin
    state_next = state;
    hit_next   = hit;
    wb         = head;
    step       = 1'b0;
    emit       = 1'b0;
    emit_kind  = KIND_TICK;
    emit_id    = '0;
    emit_last  = 1'b0;
    div_start  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          hit_next = 1'b0;
          unique case (cmd)
            CMD_TICK, CMD_CANCEL: state_next = ST_SCAN;
            CMD_ADD: begin
              div_start  = 1'b1;
              state_next = ST_DIV;
            end
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (out_free) begin
          step = 1'b1;
          unique case (op)
            CMD_TICK: begin
              if (head.id != '0 && tick >= head.deadline) begin
                emit    = 1'b1;
                emit_kind = KIND_FIRED;
                emit_id = head.id;
                if (head.period != '0) begin
                  wb.deadline = tick + TickW'(head.period);
                end else begin
                  wb.id = '0;
                end
              end
            end
            CMD_ADD: begin
              if (!hit && head.id == '0) begin
                wb.id       = next_id;
                wb.deadline = tick + TickW'(tval);
                wb.period   = per ? tval : '0;
                hit_next    = 1'b1;
              end
            end
            default: begin
              if (!hit && head.id != '0 && head.id == cid) begin
                wb.id    = '0;
                hit_next = 1'b1;
              end
            end
          endcase
          if (cnt == CW'(SLOTS - 1)) begin
            state_next = ST_FIN;
          end
        end
      end
      ST_FIN: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_last = 1'b1;
          unique case (op)
            CMD_TICK: emit_kind = KIND_TICK;
            CMD_ADD: begin
              emit_kind = hit ? KIND_ADDED : KIND_FULL;
              emit_id   = hit ? next_id : '0;
            end
            default: emit_kind = KIND_CANCEL;
          endcase
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      hit     <= 1'b0;
      cnt     <= '0;
      tick    <= '0;
      next_id <= IdW'(1);
      mpt     <= MPT_RESET;
    end else begin
      state <= state_next;
      hit   <= hit_next;
      if (cfg_we) begin
        mpt <= cfg_data;
      end
      if (accept && cmd == CMD_TICK) begin
        tick <= tick + 1'b1;
      end
      if (state == ST_IDLE) begin
        cnt <= '0;
      end else if (step) begin
        cnt <= cnt + 1'b1;
      end
      if (state == ST_FIN && out_free && op == CMD_ADD && hit) begin
        next_id <= (next_id >= ID_MAX) ? IdW'(1) : next_id + 1'b1;
      end
    end
  end

  // Item payload
  always_ff @(posedge clk) begin
    if (accept) begin
      op  <= cmd;
      per <= periodic;
      cid <= cancel_id;
    end
    if (div_done) begin
      tval <= (div_q == '0) ? DurW'(1) : div_q;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && emit) begin
      kind       <= emit_kind;
      timer_id   <= emit_id;
      tick_count <= tick;
      last       <= emit_last;
    end
  end

  // Checks
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept && cmd != CMD_NONE |=> state != ST_IDLE)
    else $error("item accepted but sequencer idle");
  a_id_nonzero: assert property (@(posedge clk) disable iff (rst)
    next_id != '0)
    else $error("next id is zero");
  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIV)
    else $error("divider done outside divide state");

endmodule
